// ----- src/pse_pkg.sv -----
`timescale 1ns / 1ps

package pse_pkg;

    localparam int FFT_LEN      = 2048;
    localparam int NYQ_BIN      = FFT_LEN / 2;

    localparam int BIN_W        = 11;
    localparam int OMEGA_W      = 24;
    localparam int KX_W         = 23;
    localparam int SMP_W        = 16;
    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 32;

    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_SLOWNESS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COS2_MAX  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_BIN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_BIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TWO_DEPTH = 3'd4;

    localparam logic [31:0] RST_SLOWNESS  = 32'd2863311;
    localparam logic [16:0] RST_COS2_MAX  = 17'd16384;
    localparam logic [10:0] RST_LOW_BIN   = 11'd0;
    localparam logic [10:0] RST_HIGH_BIN  = 11'd1024;
    localparam logic [19:0] RST_TWO_DEPTH = 20'd0;

    localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
    localparam logic signed [30:0] CORDIC_GAIN_Q30 = 31'sd652032874;

    localparam int SQ_STEPS     = 31;
    localparam int CORDIC_STEPS = 16;
    localparam int XY_W         = 35;
    localparam int Z_W          = 33;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    // stage indexes in the valid vector
    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_D   = 3;
    localparam int ST_E   = 4;
    localparam int ST_SQ  = 5;
    localparam int ST_F   = ST_SQ + SQ_STEPS;
    localparam int ST_G   = ST_F + 1;
    localparam int ST_H   = ST_G + 1;
    localparam int ST_CR  = ST_H + 1;
    localparam int ST_I   = ST_CR + CORDIC_STEPS;
    localparam int ST_J   = ST_I + 1;
    localparam int N_STG  = ST_J + 1;

endpackage

// ----- src/phase_shift_extrapolator_unit.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake              | Payload
// s stream  | in        | i_s_tvalid/o_s_tready  | i_s_tdata: freq_bin, omega, kx, src_re, src_im
// m stream  | out       | o_m_tvalid/i_m_tready  | o_m_tdata: out_re, out_im; o_m_tuser: passed
// cfg       | in        | i_cfg_we               | i_cfg_addr, i_cfg_wdata
// One transaction per cycle while the output is not stalled; the pipeline includes the 31-stage
// square root and the 16-stage CORDIC rotator.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall at the output freezes every stage; nothing is dropped or repeated.

module phase_shift_extrapolator_unit import pse_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // freq_bin[10:0], omega[34:11], kx[57:35], src_re[73:58], src_im[89:74], zero pad
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // out_re[15:0], out_im[31:16]
    output logic [M_TDATA_W-1:0]   o_m_tdata,
    // passed[0]
    output logic                   o_m_tuser,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [31:0] r_slowness;
    logic [16:0] r_cos2_max;
    logic [10:0] r_low_bin;
    logic [10:0] r_high_bin;
    logic [19:0] r_two_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slowness  <= RST_SLOWNESS;
            r_cos2_max  <= RST_COS2_MAX;
            r_low_bin   <= RST_LOW_BIN;
            r_high_bin  <= RST_HIGH_BIN;
            r_two_depth <= RST_TWO_DEPTH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SLOWNESS:  r_slowness  <= i_cfg_wdata;
                REG_COS2_MAX:  r_cos2_max  <= i_cfg_wdata[16:0];
                REG_LOW_BIN:   r_low_bin   <= i_cfg_wdata[10:0];
                REG_HIGH_BIN:  r_high_bin  <= i_cfg_wdata[10:0];
                REG_TWO_DEPTH: r_two_depth <= i_cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    logic [N_STG-1:0] r_vld;
    logic             adv;

    assign adv        = !r_vld[N_STG-1] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_vld[N_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[N_STG-2:0], i_s_tvalid};
        end
    end

    logic [BIN_W-1:0]          in_bin;
    logic [OMEGA_W-1:0]        in_omega;
    logic signed [KX_W-1:0]    in_kx;
    logic signed [SMP_W-1:0]   in_re;
    logic signed [SMP_W-1:0]   in_im;

    assign in_bin   = i_s_tdata[10:0];
    assign in_omega = i_s_tdata[34:11];
    assign in_kx    = i_s_tdata[57:35];
    assign in_re    = i_s_tdata[73:58];
    assign in_im    = i_s_tdata[89:74];

    // stage A: k product, band check
    logic [55:0]             r_a_kprod;
    logic signed [KX_W-1:0]  r_a_kx;
    logic signed [SMP_W-1:0] r_a_re, r_a_im;
    logic                    r_a_band;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_kprod <= 56'(in_omega) * 56'(r_slowness);
            r_a_kx    <= in_kx;
            r_a_re    <= in_re;
            r_a_im    <= in_im;
            r_a_band  <= (in_bin < r_low_bin) || (in_bin > r_high_bin)
                         || (32'(in_bin) > 32'(NYQ_BIN));
        end
    end

    // stage B: saturate k, magnitude of kx
    logic [30:0]             r_b_k;
    logic [22:0]             r_b_akx;
    logic signed [SMP_W-1:0] r_b_re, r_b_im;
    logic                    r_b_band;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_k    <= r_a_kprod[55] ? 31'h7FFF_FFFF : r_a_kprod[54:24];
            r_b_akx  <= r_a_kx[KX_W-1] ? 23'(-r_a_kx) : 23'(r_a_kx);
            r_b_re   <= r_a_re;
            r_b_im   <= r_a_im;
            r_b_band <= r_a_band;
        end
    end

    // stage C: squares
    logic [61:0]             r_c_ksq;
    logic [45:0]             r_c_kxsq;
    logic signed [SMP_W-1:0] r_c_re, r_c_im;
    logic                    r_c_band;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_ksq  <= 62'(r_b_k) * 62'(r_b_k);
            r_c_kxsq <= 46'(r_b_akx) * 46'(r_b_akx);
            r_c_re   <= r_b_re;
            r_c_im   <= r_b_im;
            r_c_band <= r_b_band;
        end
    end

    // stage D: difference, angle threshold partial products
    logic                    r_d_evan;
    logic [61:0]             r_d_a;
    logic [46:0]             r_d_phi;
    logic [48:0]             r_d_plo;
    logic signed [SMP_W-1:0] r_d_re, r_d_im;
    logic                    r_d_band;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_evan <= 62'(r_c_kxsq) > r_c_ksq;
            r_d_a    <= r_c_ksq - 62'(r_c_kxsq);
            r_d_phi  <= 47'(r_cos2_max) * 47'(r_c_ksq[61:32]);
            r_d_plo  <= 49'(r_cos2_max) * 49'(r_c_ksq[31:0]);
            r_d_re   <= r_c_re;
            r_d_im   <= r_c_im;
            r_d_band <= r_c_band;
        end
    end

    // stage E: angle compare, square root entry
    logic [61:0]             r_sq_rem  [SQ_STEPS+1];
    logic [30:0]             r_sq_root [SQ_STEPS+1];
    logic signed [SMP_W-1:0] r_sq_re   [SQ_STEPS+1];
    logic signed [SMP_W-1:0] r_sq_im   [SQ_STEPS+1];
    logic                    r_sq_pass [SQ_STEPS+1];
    logic [63:0]             thr;

    assign thr = {1'b0, r_d_phi, 16'd0} + 64'(r_d_plo[48:16]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0]  <= r_d_a;
            r_sq_root[0] <= '0;
            r_sq_re[0]   <= r_d_re;
            r_sq_im[0]   <= r_d_im;
            r_sq_pass[0] <= !r_d_band && !r_d_evan && (64'(r_d_a) > thr);
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        localparam int B = SQ_STEPS - 1 - j;
        logic [63:0] trial;
        logic        take;

        assign trial = (64'(r_sq_root[j]) << (B + 1)) + (64'd1 << (2 * B));
        assign take  = 64'(r_sq_rem[j]) >= trial;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[j+1]  <= take ? 62'(64'(r_sq_rem[j]) - trial) : r_sq_rem[j];
                r_sq_root[j+1] <= take ? (r_sq_root[j] | (31'd1 << B)) : r_sq_root[j];
                r_sq_re[j+1]   <= r_sq_re[j];
                r_sq_im[j+1]   <= r_sq_im[j];
                r_sq_pass[j+1] <= r_sq_pass[j];
            end
        end
    end

    // stage F: phase
    logic [50:0]             r_f_p;
    logic signed [SMP_W-1:0] r_f_re, r_f_im;
    logic                    r_f_pass;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_p    <= 51'(r_two_depth) * 51'(r_sq_root[SQ_STEPS]);
            r_f_re   <= r_sq_re[SQ_STEPS];
            r_f_im   <= r_sq_im[SQ_STEPS];
            r_f_pass <= r_sq_pass[SQ_STEPS];
        end
    end

    // stage G: phase to turns, partial products
    logic [48:0]             r_g_hi;
    logic [61:0]             r_g_lo;
    logic signed [SMP_W-1:0] r_g_re, r_g_im;
    logic                    r_g_pass;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_hi   <= 49'(r_f_p[50:32]) * 49'(INV_TWO_PI_Q32);
            r_g_lo   <= 62'(r_f_p[31:0]) * 62'(INV_TWO_PI_Q32);
            r_g_re   <= r_f_re;
            r_g_im   <= r_f_im;
            r_g_pass <= r_f_pass;
        end
    end

    // stage H: fold angle into the quarter turns either side of zero
    logic signed [XY_W-1:0] r_cx [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] r_cy [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  r_cz [CORDIC_STEPS+1];
    logic                   r_cp [CORDIC_STEPS+1];
    logic [31:0]            turns;
    logic [31:0]            ang;
    logic                   flip;
    logic signed [XY_W-1:0] x0, y0;

    assign turns = {r_g_hi[23:0], 8'd0} + r_g_lo[55:24];
    assign ang   = 32'd0 - turns;
    assign flip  = ang[31] ^ ang[30];
    assign x0    = XY_W'(r_g_re) <<< 16;
    assign y0    = XY_W'(r_g_im) <<< 16;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx[0] <= flip ? -x0 : x0;
            r_cy[0] <= flip ? -y0 : y0;
            r_cz[0] <= flip ? Z_W'($signed({~ang[31], ang[30:0]}))
                            : Z_W'($signed(ang));
            r_cp[0] <= r_g_pass;
        end
    end

    // CORDIC rotation, one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cr
        logic signed [XY_W-1:0] xs, ys;
        logic signed [Z_W-1:0]  at;
        logic                   pos;

        assign xs  = r_cx[i] >>> i;
        assign ys  = r_cy[i] >>> i;
        assign at  = $signed(Z_W'(ATAN_TURNS[i]));
        assign pos = !r_cz[i][Z_W-1];

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cx[i+1] <= pos ? r_cx[i] - ys : r_cx[i] + ys;
                r_cy[i+1] <= pos ? r_cy[i] + xs : r_cy[i] - xs;
                r_cz[i+1] <= pos ? r_cz[i] - at : r_cz[i] + at;
                r_cp[i+1] <= r_cp[i];
            end
        end
    end

    // stage I: gain correction
    logic signed [65:0] r_i_mx, r_i_my;
    logic               r_i_pass;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_i_mx   <= 66'(r_cx[CORDIC_STEPS]) * 66'(CORDIC_GAIN_Q30);
            r_i_my   <= 66'(r_cy[CORDIC_STEPS]) * 66'(CORDIC_GAIN_Q30);
            r_i_pass <= r_cp[CORDIC_STEPS];
        end
    end

    // stage J: round, saturate, zero rejected transactions
    logic signed [65:0] rnd_x, rnd_y;
    logic signed [19:0] sh_x, sh_y;
    logic signed [15:0] n_out_re, n_out_im;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic                 r_m_tuser;

    assign rnd_x = (r_i_mx + (66'sd1 <<< 45)) >>> 46;
    assign rnd_y = (r_i_my + (66'sd1 <<< 45)) >>> 46;
    assign sh_x  = rnd_x[19:0];
    assign sh_y  = rnd_y[19:0];

    always_comb begin
        if (sh_x > 20'sd32767) begin
            n_out_re = 16'sh7FFF;
        end else if (sh_x < -20'sd32768) begin
            n_out_re = 16'sh8000;
        end else begin
            n_out_re = sh_x[15:0];
        end
        if (sh_y > 20'sd32767) begin
            n_out_im = 16'sh7FFF;
        end else if (sh_y < -20'sd32768) begin
            n_out_im = 16'sh8000;
        end else begin
            n_out_im = sh_y[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_tdata <= r_i_pass ? {n_out_im, n_out_re} : '0;
            r_m_tuser <= r_i_pass;
        end
    end

    assign o_m_tdata = r_m_tdata;
    assign o_m_tuser = r_m_tuser;

endmodule

// ----- src/pse_chk.sv -----
`timescale 1ns / 1ps

module pse_chk import pse_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_TDATA_W-1:0]  o_m_tdata,
    input logic                  o_m_tuser
);

    a_zero_when_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("rejected transaction carries non-zero data");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind phase_shift_extrapolator_unit pse_chk u_chk (.*);

// ----- test/phase_shift_extrapolator_unit_tb.sv -----
`timescale 1ns / 1ps

module phase_shift_extrapolator_unit_tb;
    import pse_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [63:0] sh_slowness, sh_cos2, sh_low, sh_high, sh_two_depth;
    logic [32:0] rotated_q[$];
    int          n_errors = 0;
    int          src_idle_pct = 35;
    int          snk_idle_pct = 35;

    phase_shift_extrapolator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // result {passed, im, re} for one sample under the shadow registers
    function automatic logic [32:0] extrapolate(logic [S_TDATA_W-1:0] d);
        logic [63:0] bin, omega, k, ksq, akx, kxsq, a, thr, kz, prod, ph, pl, t;
        logic [63:0] rem, root, bit_v;
        logic [31:0] ang;
        longint      kx, x, y, z, nx;
        bin   = 64'(d[10:0]);
        omega = 64'(d[34:11]);
        kx    = longint'($signed(d[57:35]));
        x     = longint'($signed(d[73:58])) * 65536;
        y     = longint'($signed(d[89:74])) * 65536;
        if (bin < sh_low || bin > sh_high || bin > 64'(NYQ_BIN)) return '0;
        k = (omega * sh_slowness) >> 24;
        if (k > 64'h7FFF_FFFF) k = 64'h7FFF_FFFF;
        ksq  = k * k;
        akx  = (kx < 0) ? 64'(-kx) : 64'(kx);
        kxsq = akx * akx;
        if (kxsq > ksq) return '0;
        a   = ksq - kxsq;
        thr = ((sh_cos2 * (ksq >> 32)) << 16) + ((sh_cos2 * (ksq & 64'hFFFF_FFFF)) >> 16);
        if (a <= thr) return '0;
        rem = a;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > rem) bit_v >>= 2;
        while (bit_v != 0) begin
            if (rem >= root + bit_v) begin
                rem  = rem - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root = root >> 1;
            end
            bit_v >>= 2;
        end
        kz   = root;
        prod = sh_two_depth * kz;
        ph   = prod >> 32;
        pl   = prod & 64'hFFFF_FFFF;
        t    = ((ph * 64'(INV_TWO_PI_Q32)) << 8) + ((pl * 64'(INV_TWO_PI_Q32)) >> 24);
        ang  = 32'd0 - t[31:0];
        if (ang >= 32'h4000_0000 && ang < 32'hC000_0000) begin
            x = -x;
            y = -y;
            z = longint'({32'd0, ang}) - 64'sh8000_0000;
        end else if (ang >= 32'hC000_0000) begin
            z = longint'({32'd0, ang}) - 64'sh1_0000_0000;
        end else begin
            z = longint'({32'd0, ang});
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'({32'd0, ATAN_TURNS[i]});
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'({32'd0, ATAN_TURNS[i]});
            end
            x = nx;
        end
        x = (x * longint'(CORDIC_GAIN_Q30) + (64'sd1 <<< 45)) >>> 46;
        y = (y * longint'(CORDIC_GAIN_Q30) + (64'sd1 <<< 45)) >>> 46;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return {1'b1, 16'(y), 16'(x)};
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        n_errors++;
    endtask

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk) begin
        logic [32:0] want;
        if (rst_n && m_tvalid && m_tready) begin
            if (rotated_q.size() == 0) begin
                report("unexpected transaction", int'(m_tdata), 0);
            end else begin
                want = rotated_q.pop_front();
                if (m_tdata[15:0] !== want[15:0])
                    report("out_re", int'($signed(m_tdata[15:0])), int'($signed(want[15:0])));
                if (m_tdata[31:16] !== want[31:16])
                    report("out_im", int'($signed(m_tdata[31:16])), int'($signed(want[31:16])));
                if (m_tuser !== want[32])
                    report("passed", int'(m_tuser), int'(want[32]));
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SLOWNESS:  sh_slowness  = 64'(val);
            REG_COS2_MAX:  sh_cos2      = 64'(val[16:0]);
            REG_LOW_BIN:   sh_low       = 64'(val[10:0]);
            REG_HIGH_BIN:  sh_high      = 64'(val[10:0]);
            REG_TWO_DEPTH: sh_two_depth = 64'(val[19:0]);
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [10:0] bin, input logic [23:0] omega,
                               input logic [22:0] kx, input logic [15:0] re,
                               input logic [15:0] im);
        logic [S_TDATA_W-1:0] d;
        d = {6'd0, im, re, kx, omega, bin};
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        rotated_q.push_back(extrapolate(d));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // sample whose kx is a random fraction of k, so most pass the angle test
    task automatic send_propagating();
        logic [63:0] k, kmax;
        logic [23:0] omega;
        logic [22:0] kx;
        omega = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(16777215 >> 4));
        k = (64'(omega) * sh_slowness) >> 24;
        if (k > 64'h7FFF_FFFF) k = 64'h7FFF_FFFF;
        kmax = (k * 64'($urandom_range(1000))) / 1000;
        if (kmax > 64'd4194303) kmax = 64'd4194303;
        kx = 23'({$urandom, $urandom} % (kmax + 1));
        if ($urandom_range(1)) kx = -kx;
        send_sample(11'($urandom_range(32'(sh_high), 32'(sh_low))), omega, kx,
                    16'($urandom), 16'($urandom));
    endtask

    task automatic send_noise();
        send_sample(11'($urandom), 24'($urandom), 23'($urandom), 16'($urandom),
                    16'($urandom));
    endtask

    task automatic test_directed();
        write_reg(REG_TWO_DEPTH, 32'd16000);
        send_sample(11'd0, 24'd4096000, 23'd0, 16'h7FFF, 16'h8000);
        send_sample(11'd1024, 24'd4096000, 23'd100000, 16'h8000, 16'h7FFF);
        send_sample(11'd1025, 24'd4096000, 23'd0, 16'h7FFF, 16'h7FFF);
        send_sample(11'd2047, 24'hFFFFFF, 23'h400000, 16'h8000, 16'h8000);
        send_sample(11'd5, 24'd4096, 23'h3FFFFF, 16'h1234, 16'hABCD);
        send_sample(11'd5, 24'd4096000, 23'd2000000, 16'h4000, 16'h0);
        send_sample(11'd5, 24'd0, 23'd0, 16'h4000, 16'h4000);
        send_sample(11'd5, 24'hFFFFFF, 23'd0, 16'h0, 16'h0);
        drain();
        write_reg(REG_HIGH_BIN, 32'd2047);
        write_reg(REG_LOW_BIN, 32'd3);
        send_sample(11'd2, 24'd4096000, 23'd0, 16'h7FFF, 16'h7FFF);
        send_sample(11'd3, 24'd4096000, 23'd0, 16'h7FFF, 16'h7FFF);
        send_sample(11'd1500, 24'd4096000, 23'd0, 16'h7FFF, 16'h7FFF);
        drain();
        write_reg(REG_SLOWNESS, 32'hFFFF_FFFF);
        write_reg(REG_COS2_MAX, 32'd0);
        write_reg(REG_TWO_DEPTH, 32'hFFFFF);
        write_reg(3'd5, 32'd0);
        write_reg(3'd7, 32'hFFFF_FFFF);
        send_sample(11'd100, 24'hFFFFFF, 23'h3FFFFF, 16'h7FFF, 16'h8000);
        send_sample(11'd100, 24'hFFFFFF, 23'd0, 16'h8000, 16'h8000);
        send_sample(11'd100, 24'h800000, 23'h400000, 16'h7FFF, 16'h7FFF);
        drain();
        write_reg(REG_COS2_MAX, 32'd65536);
        send_sample(11'd100, 24'hFFFFFF, 23'd0, 16'h7FFF, 16'h7FFF);
        drain();
        write_reg(REG_COS2_MAX, 32'h1FFFF);
        send_sample(11'd100, 24'hFFFFFF, 23'd0, 16'h7FFF, 16'h7FFF);
        drain();
    endtask

    task automatic test_settings();
        logic [31:0] slow_set [6] = '{32'd2863311, 32'hFFFF_FFFF, 32'd0,
                                      32'd1431655, 32'd5726622, 32'd2863311};
        logic [16:0] cos2_set [6] = '{17'd16384, 17'd0, 17'd65535, 17'd65536,
                                      17'd32768, 17'd1};
        for (int s = 0; s < 6; s++) begin
            write_reg(REG_SLOWNESS, slow_set[s]);
            write_reg(REG_COS2_MAX, 32'(cos2_set[s]));
            write_reg(REG_LOW_BIN, 32'($urandom_range(200)));
            write_reg(REG_HIGH_BIN, (s == 1) ? 32'd2047 : 32'($urandom_range(1024, 900)));
            write_reg(REG_TWO_DEPTH, (s == 2) ? 32'hFFFFF : 32'($urandom));
            repeat (60) begin
                if ($urandom_range(9) < 7) send_propagating();
                else send_noise();
            end
            drain();
        end
    endtask

    task automatic test_random();
        write_reg(REG_SLOWNESS, 32'd2863311);
        write_reg(REG_COS2_MAX, 32'd16384);
        write_reg(REG_LOW_BIN, 32'd0);
        write_reg(REG_HIGH_BIN, 32'd1024);
        write_reg(REG_TWO_DEPTH, 32'd40000);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (300) send_propagating();
        src_idle_pct = 35;
        snk_idle_pct = 35;
        for (int n = 0; n < 550; n++) begin
            if ($urandom_range(9) < 8) send_propagating();
            else send_noise();
        end
        drain();
        write_reg(REG_TWO_DEPTH, $urandom);
        write_reg(REG_SLOWNESS, 32'($urandom_range(8000000, 1000000)));
        repeat (300) begin
            if ($urandom_range(9) < 8) send_propagating();
            else send_noise();
        end
        drain();
    endtask

    initial begin
        sh_slowness  = 64'(RST_SLOWNESS);
        sh_cos2      = 64'(RST_COS2_MAX);
        sh_low       = 64'(RST_LOW_BIN);
        sh_high      = 64'(RST_HIGH_BIN);
        sh_two_depth = 64'(RST_TWO_DEPTH);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_random();
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pse_pkg.sv
src/phase_shift_extrapolator_unit.sv
src/pse_chk.sv
test/phase_shift_extrapolator_unit_tb.sv
